@@ rtl/core/paced_test_packet_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Paced test packet sequencer assertion macros
// Shared property wrappers; the including module supplies clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef PACED_TEST_PACKET_SEQUENCER_DEFINES_SVH
`define PACED_TEST_PACKET_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define PTPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptps assertion failed");

// next-cycle implication
`define PTPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptps assertion failed");

`endif

@@ rtl/core/ptps_pkg.sv @@
// ----------------------------------------------------------------------------
// ptps_pkg
// Types, constants and codes shared by the paced test packet sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptps_pkg;

	localparam int MAX_PER_TICK_DEF = 63;

	localparam int PPT_W   = 6;
	localparam int EPM_W   = 10;
	localparam int LAP_W   = 16;
	localparam int CNT32_W = 32;
	localparam int SEC_W   = 32;
	localparam int USEC_W  = 20;
	localparam int MK_W    = 3;
	localparam int CREDIT_W = 11;
	localparam int US_W    = 53;  // sec * 1e6 + usec, usec up to 2^20-1

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int IN_TDATA_W  = 56;   // sec, usec, pad
	localparam int OUT_TDATA_W = 152;  // marker, seq, sec, usec, min, max, pad

	localparam logic [USEC_W-1:0]   USEC_PER_SEC = 20'd1000000;
	localparam logic [CREDIT_W-1:0] CREDIT_FULL  = 11'd1000;
	localparam logic [CNT32_W-1:0]  GAP_MIN_INIT = 32'h07FF_FFFF;

	localparam logic [PPT_W-1:0]   PPT_RST   = 6'd1;
	localparam logic [EPM_W-1:0]   EPM_RST   = 10'd0;
	localparam logic [LAP_W-1:0]   LAP_RST   = 16'd100;
	localparam logic [CNT32_W-1:0] TOTAL_RST = 32'd10000;

	typedef enum logic [MK_W-1:0] {
		MK_START = 3'd0,
		MK_CONT  = 3'd1,
		MK_LAP   = 3'd2,
		MK_END   = 3'd3,
		MK_FIN   = 3'd4
	} ptps_marker_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PPT   = 2'd0,
		CFG_EPM   = 2'd1,
		CFG_LAP   = 2'd2,
		CFG_TOTAL = 2'd3
	} ptps_cfg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch input request
		logic prod;      // sec * 1e6
		logic sum;       // + usec
		logic gap;       // gap, prev time, credit, count, start remainder
		logic upd;       // min/max update
		logic rem_load;  // take lap remainder
		logic emit;      // load one packet stamp
		logic fin;       // load finish stamp
	} ptps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic running;
		logic div_done;
		logic n_zero;
		logic emit_last;
		logic out_free;
	} ptps_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/paced_test_packet_sequencer.sv @@
// ----------------------------------------------------------------------------
// paced_test_packet_sequencer
// Turns timer tick and finish requests into a paced stream of packet stamps.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request per handshake: tuser = func (0 tick,
//   1 finish), tdata = time stamp seconds and microseconds.
//   Master channel gives one packet stamp per handshake; tlast marks the
//   final stamp caused by a request.
//   cfg_wr_en/cfg_addr/cfg_wdata write the four rate registers; write only
//   while the block is idle.
// Timing:
//   A tick runs a gap pipeline (multiply, add, subtract/saturate, min/max)
//   while the bit-serial lap remainder unit, started at the subtract step,
//   works out the lap remainder; the first stamp is loaded once it is done.
//   Stamps then leave one per cycle while the receiver is ready, n stamps
//   per tick (n up to MAX_PER_TICK + 1). A finish request loads one stamp.
//   A tick on a stopped stream is dropped.
// Reset: registers return to their defaults, count and credit clear, the
//   stream is marked running. Receiver stall holds the output register and
//   pauses emission; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module paced_test_packet_sequencer import ptps_pkg::*; #(
	parameter int MAX_PER_TICK = MAX_PER_TICK_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,   // stamp_sec, stamp_usec, pad
	input  wire logic                  s_tuser,   // func
	// stamp channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_TDATA_W-1:0]     m_tdata,   // marker, sequence_res, out_sec,
	                                              // out_usec, min_gap, max_gap, pad
	output logic                       m_tlast    // last_of_run
);

	ptps_cmd_t  cmd;
	ptps_stat_t stat;

	// sequencing: which step of a request runs this cycle
	ptps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// all arithmetic, state and the output register
	ptps_dp #(
		.MAX_PER_TICK (MAX_PER_TICK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

@@ rtl/core/ptps_rem_div.sv @@
// ----------------------------------------------------------------------------
// ptps_rem_div
// Bit-serial remainder unit: count mod lap interval, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptps_rem_div import ptps_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [CNT32_W-1:0] dividend,
	input  wire logic [LAP_W-1:0]   divisor,
	output logic                    busy,
	output logic [LAP_W-1:0]        rem
);

	localparam int BIT_W = $clog2(CNT32_W);

	logic               busy_q;
	logic [BIT_W-1:0]   bit_q;
	logic [CNT32_W-1:0] dvd_q;
	logic [LAP_W-1:0]   rem_q;
	logic [LAP_W:0]     trial;
	logic [LAP_W:0]     trial_sub;

	assign trial     = {rem_q, dvd_q[CNT32_W-1]};
	assign trial_sub = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q  <= '0;
		end else if (busy_q) begin
			bit_q <= bit_q + BIT_W'(1);
			if (bit_q == BIT_W'(CNT32_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CNT32_W-2:0], 1'b0};
			rem_q <= trial_sub[LAP_W-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/ptps_dp.sv @@
// ----------------------------------------------------------------------------
// ptps_dp
// Datapath: config registers, gap tracking, credit, sequence and output reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "paced_test_packet_sequencer_defines.svh"

module ptps_dp import ptps_pkg::*; #(
	parameter int MAX_PER_TICK = MAX_PER_TICK_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast,
	input  wire ptps_cmd_t              cmd,
	output ptps_stat_t                  stat
);

	localparam int CNT_W = $clog2(MAX_PER_TICK + 2);
	localparam logic [PPT_W-1:0] MAX_WHOLE = PPT_W'(MAX_PER_TICK);

	// config
	logic [PPT_W-1:0]   ppt_q;
	logic [EPM_W-1:0]   epm_q;
	logic [LAP_W-1:0]   lap_q;
	logic [CNT32_W-1:0] total_q;

	// state
	logic [CNT32_W-1:0]  sent_q;
	logic [CREDIT_W-1:0] credit_q;
	logic                running_q;
	logic [US_W-1:0]     prev_us_q;
	logic [CNT32_W-1:0]  min_q;
	logic [CNT32_W-1:0]  max_q;

	// item and gap pipeline
	logic [SEC_W-1:0]   sec_q;
	logic [USEC_W-1:0]  usec_q;
	logic [US_W-2:0]    prod_s1;
	logic [US_W-1:0]    now_s2;
	logic [CNT32_W-1:0] gap_s3;

	// emission
	logic [LAP_W-1:0] rem_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] idx_q;

	// output register
	logic               ovalid_q;
	logic [MK_W-1:0]    mk_q;
	logic [CNT32_W-1:0] seq_q;
	logic [SEC_W-1:0]   osec_q;
	logic [USEC_W-1:0]  ousec_q;
	logic [CNT32_W-1:0] omin_q;
	logic [CNT32_W-1:0] omax_q;
	logic               last_q;

	// divider
	logic             div_busy;
	logic [LAP_W-1:0] div_rem;

	// comb
	logic [US_W:0]       diff;
	logic [CNT32_W-1:0]  gap_sat;
	logic [CREDIT_W-1:0] credit_sum;
	logic                extra;
	logic [PPT_W-1:0]    whole;
	logic [CNT32_W-1:0]  cnt_next;
	logic [LAP_W:0]      rem_inc;
	logic [LAP_W-1:0]    rem_next;
	ptps_marker_t        mk_next;
	logic                emit_last;
	logic                out_free;

	ptps_rem_div u_rem_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.gap),
		.dividend (sent_q),
		.divisor  (lap_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppt_q   <= PPT_RST;
			epm_q   <= EPM_RST;
			lap_q   <= LAP_RST;
			total_q <= TOTAL_RST;
		end else if (cfg_wr_en) begin
			case (ptps_cfg_idx_t'(cfg_addr))
				CFG_PPT:   ppt_q   <= cfg_wdata[PPT_W-1:0];
				CFG_EPM:   epm_q   <= cfg_wdata[EPM_W-1:0];
				CFG_LAP:   lap_q   <= cfg_wdata[LAP_W-1:0];
				CFG_TOTAL: total_q <= cfg_wdata[CNT32_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated gap against previous tick
	assign diff = {1'b0, now_s2} - {1'b0, prev_us_q};
	always_comb begin
		if (diff[US_W])
			gap_sat = '0;
		else if (|diff[US_W-1:CNT32_W])
			gap_sat = '1;
		else
			gap_sat = diff[CNT32_W-1:0];
	end

	assign credit_sum = credit_q + CREDIT_W'(epm_q);
	assign extra      = (credit_sum >= CREDIT_FULL);
	assign whole      = (ppt_q > MAX_WHOLE) ? MAX_WHOLE : ppt_q;

	// next stamp; a count wrapping to zero is a multiple of any interval
	assign cnt_next = sent_q + 32'd1;
	assign rem_inc  = {1'b0, rem_q} + 17'd1;
	assign rem_next = ((rem_inc == {1'b0, lap_q}) || (cnt_next == '0)) ? '0
	                                                                   : rem_inc[LAP_W-1:0];

	always_comb begin
		if (cnt_next == 32'd1)
			mk_next = MK_START;
		else if (cnt_next >= total_q)
			mk_next = MK_END;
		else if ((lap_q != '0) && (rem_next == '0))
			mk_next = MK_LAP;
		else
			mk_next = MK_CONT;
	end

	assign emit_last = (idx_q == (n_q - CNT_W'(1)));
	assign out_free  = !ovalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sec_q  <= s_tdata[SEC_W-1:0];
			usec_q <= s_tdata[SEC_W+USEC_W-1:SEC_W];
		end
		if (cmd.prod)
			prod_s1 <= (US_W-1)'(sec_q) * (US_W-1)'(USEC_PER_SEC);
		if (cmd.sum)
			now_s2 <= {1'b0, prod_s1} + US_W'(usec_q);
		if (cmd.gap) begin
			gap_s3 <= gap_sat;
			n_q    <= CNT_W'(whole) + CNT_W'(extra);
		end
		if (cmd.rem_load)
			rem_q <= div_rem;
		else if (cmd.emit)
			rem_q <= rem_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q    <= '0;
			credit_q  <= '0;
			running_q <= 1'b1;
			prev_us_q <= '0;
			min_q     <= GAP_MIN_INIT;
			max_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.gap) begin
				prev_us_q <= now_s2;
				credit_q  <= extra ? (credit_sum - CREDIT_FULL) : credit_sum;
				idx_q     <= '0;
			end
			if (cmd.upd && (sent_q > 32'd1)) begin
				if (gap_s3 < min_q)
					min_q <= gap_s3;
				if (gap_s3 > max_q)
					max_q <= gap_s3;
			end
			if (cmd.emit) begin
				sent_q <= cnt_next;
				idx_q  <= idx_q + CNT_W'(1);
				if (mk_next == MK_END)
					running_q <= 1'b0;
			end else if (cmd.fin) begin
				sent_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit || cmd.fin)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.fin) begin
			mk_q    <= cmd.fin ? MK_FIN : mk_next;
			seq_q   <= cnt_next;
			osec_q  <= sec_q;
			ousec_q <= usec_q;
			omin_q  <= min_q;
			omax_q  <= max_q;
			last_q  <= cmd.fin ? 1'b1 : emit_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, omax_q, omin_q, ousec_q, osec_q, seq_q, mk_q};

	assign stat.running   = running_q;
	assign stat.div_done  = !div_busy;
	assign stat.n_zero    = (n_q == '0);
	assign stat.emit_last = emit_last;
	assign stat.out_free  = out_free;

	`PTPS_ASSERT_NXT(a_running_sticky, !running_q, !running_q)
	`PTPS_ASSERT_IMP(a_load_into_free_slot, cmd.emit || cmd.fin, out_free)
	`PTPS_ASSERT_NXT(a_seq_follows_count, cmd.emit || cmd.fin, seq_q == $past(sent_q) + 32'd1)

endmodule

`default_nettype wire

@@ rtl/core/ptps_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptps_ctrl
// Controller: sequences gap pipeline, remainder wait and stamp emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ptps_ctrl import ptps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tuser,
	output logic            s_tready,
	input  wire ptps_stat_t stat,
	output ptps_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_SUM,
		ST_GAP,
		ST_UPD,
		ST_WAIT,
		ST_EMIT,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.prod     = (state_q == ST_PROD);
		cmd.sum      = (state_q == ST_SUM);
		cmd.gap      = (state_q == ST_GAP);
		cmd.upd      = (state_q == ST_UPD);
		cmd.rem_load = (state_q == ST_WAIT) && stat.div_done;
		cmd.emit     = (state_q == ST_EMIT) && stat.out_free;
		cmd.fin      = (state_q == ST_FIN) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser)
							state_q <= ST_FIN;
						else if (stat.running)
							state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_GAP;
				ST_GAP:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.div_done)
						state_q <= stat.n_zero ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free && stat.emit_last)
						state_q <= ST_IDLE;
				end
				ST_FIN: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/paced_test_packet_sequencer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paced_test_packet_sequencer_test
// Self-checking bench for the packet stamp sequencer. A queue-fed driver
// offers tick and finish requests. Each accepted request runs through a
// behavioral predictor that keeps its own count, credit, gap and rate
// state. A monitor checks every stamp against the oldest predicted one.
// The run covers directed corner cases, random phases under several idle
// and stall mixes, a long receiver hold-off, and the end of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module paced_test_packet_sequencer_test;
	import ptps_pkg::*;

	localparam int DRAIN_CYCLES = 120;     // above the worst tick latency
	localparam int HOLD_CYCLES  = 400;     // receiver hold-off in the pressure phase
	localparam int SETTLE_LIMIT = 100000;  // cycles to wait for a phase to drain

	typedef struct packed {
		logic              func;   // 0 tick, 1 finish
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
	} tick_req_t;

	typedef struct packed {
		ptps_marker_t       marker;
		logic [CNT32_W-1:0] seq;
		logic [SEC_W-1:0]   sec;
		logic [USEC_W-1:0]  usec;
		logic               last;
		logic [CNT32_W-1:0] min_gap;
		logic [CNT32_W-1:0] max_gap;
	} stamp_t;

	// DUT connections
	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // stamp_sec, stamp_usec, pad
	logic                   s_tuser = 1'b0; // func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // marker, sequence_res, out_sec, out_usec,
	                                        // min_gap, max_gap, pad
	logic                   m_tlast;        // last_of_run

	// request and stamp bookkeeping
	tick_req_t req_queue[$];   // requests waiting for the driver
	stamp_t    stamps_due[$];  // predicted stamps, oldest first
	int        reqs_queued = 0;
	int        reqs_taken = 0;
	int        ticks_taken = 0;
	int        finishes_taken = 0;
	int        stamps_seen = 0;
	int        lap_marks = 0;
	int        end_marks = 0;
	int        reg_writes = 0;
	int        fail_count = 0;

	// idle / stall mix, percent per cycle
	int send_idle_pct = 0;
	int stall_pct = 0;

	// long receiver hold-off
	logic hold_go = 1'b0;
	int   hold_left = 0;

	// wall clock used for well-formed, forward-moving tick times
	logic [SEC_W-1:0]  wall_sec = 32'd2;
	logic [USEC_W-1:0] wall_usec = '0;

	// predictor state, reset values
	logic [CNT32_W-1:0]  seq_count = '0;
	logic [CREDIT_W-1:0] credit_acc = '0;
	logic                stream_live = 1'b1;
	logic [SEC_W-1:0]    last_sec = '0;
	logic [USEC_W-1:0]   last_usec = '0;
	logic [CNT32_W-1:0]  gap_lo = GAP_MIN_INIT;
	logic [CNT32_W-1:0]  gap_hi = '0;

	// predictor copy of the rate registers
	logic [PPT_W-1:0]   rate_ppt = PPT_RST;
	logic [EPM_W-1:0]   rate_epm = EPM_RST;
	logic [LAP_W-1:0]   rate_lap = LAP_RST;
	logic [CNT32_W-1:0] rate_total = TOTAL_RST;

	paced_test_packet_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Bumps the count and picks the marker for one packet stamp.
	// The very first stamp is always start; end overrides lap.
	function automatic ptps_marker_t next_stamp_marker();
		ptps_marker_t mk;
		mk = MK_CONT;
		seq_count = seq_count + 32'd1;
		if (seq_count == 32'd1)
			return MK_START;
		if ((rate_lap != '0) && ((seq_count % {16'd0, rate_lap}) == 32'd0))
			mk = MK_LAP;
		if (seq_count >= rate_total) begin
			stream_live = 1'b0;
			mk = MK_END;
		end
		return mk;
	endfunction

	// Works out every stamp an accepted request causes and queues them.
	function automatic void forecast_stamps(tick_req_t r);
		stamp_t              s;
		logic [63:0]         now_us;
		logic [63:0]         then_us;
		logic [63:0]         diff;
		logic [CNT32_W-1:0]  gap;
		logic [CREDIT_W-1:0] next_credit;
		logic                extra;
		int                  whole;
		int                  n_out;
		int                  i;
		s = '0;
		s.sec = r.sec;
		s.usec = r.usec;
		// finish: one stamp, counts, touches nothing else even when stopped
		if (r.func) begin
			finishes_taken++;
			seq_count = seq_count + 32'd1;
			s.marker = MK_FIN;
			s.seq = seq_count;
			s.min_gap = gap_lo;
			s.max_gap = gap_hi;
			s.last = 1'b1;
			stamps_due.push_back(s);
			return;
		end
		ticks_taken++;
		// stopped stream drops ticks without a trace
		if (!stream_live)
			return;
		// gaps only count once two stamps have gone out
		if (seq_count > 32'd1) begin
			now_us = {32'd0, r.sec} * 64'd1000000 + {44'd0, r.usec};
			then_us = {32'd0, last_sec} * 64'd1000000 + {44'd0, last_usec};
			diff = now_us - then_us;
			if (now_us < then_us)
				gap = '0;
			else if (diff > 64'hFFFF_FFFF)
				gap = '1;
			else
				gap = diff[31:0];
			if (gap < gap_lo)
				gap_lo = gap;
			if (gap > gap_hi)
				gap_hi = gap;
		end
		last_sec = r.sec;
		last_usec = r.usec;

		whole = int'(rate_ppt);
		if (whole > MAX_PER_TICK_DEF)
			whole = MAX_PER_TICK_DEF;
		// credit takes at most one extra stamp per tick, remainder stays
		next_credit = credit_acc + {1'b0, rate_epm};
		extra = (next_credit >= CREDIT_FULL);
		if (extra)
			next_credit = next_credit - CREDIT_FULL;
		credit_acc = next_credit;
		n_out = whole + (extra ? 1 : 0);

		s.min_gap = gap_lo;
		s.max_gap = gap_hi;
		for (i = 0; i < n_out; i++) begin
			s.marker = next_stamp_marker();
			s.seq = seq_count;
			s.last = (i == n_out - 1);
			if (s.marker == MK_LAP)
				lap_marks++;
			if (s.marker == MK_END)
				end_marks++;
			stamps_due.push_back(s);
		end
	endfunction

	function automatic void check_field(string fld, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fld, want, got);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: one request per handshake, fed from req_queue
	// ------------------------------------------------------------------------
	tick_req_t on_bus = '0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				forecast_stamps(on_bus);
				reqs_taken++;
			end
			// load the next request only when the bus is free or just taken
			if (!s_tvalid || s_tready) begin
				if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_bus.func;
					s_tdata <= {{(IN_TDATA_W - SEC_W - USEC_W){1'b0}}, on_bus.usec, on_bus.sec};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// hold-off counter, started by a one-cycle pulse on hold_go
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each stamp with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		stamp_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				stamps_seen++;
				if (stamps_due.size() == 0) begin
					$error("stamp with sequence %0d arrived with none expected", m_tdata[34:3]);
					fail_count++;
				end else begin
					want = stamps_due.pop_front();
					check_field("marker", 32'(want.marker), 32'(m_tdata[2:0]));
					check_field("sequence_res", want.seq, m_tdata[34:3]);
					check_field("out_sec", want.sec, m_tdata[66:35]);
					check_field("out_usec", 32'(want.usec), 32'(m_tdata[86:67]));
					check_field("last_of_run", 32'(want.last), 32'(m_tlast));
					check_field("min_gap", want.min_gap, m_tdata[118:87]);
					check_field("max_gap", want.max_gap, m_tdata[150:119]);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Register write; only called with the block idle.
	task automatic write_reg(ptps_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_PPT:   rate_ppt = val[PPT_W-1:0];
			CFG_EPM:   rate_epm = val[EPM_W-1:0];
			CFG_LAP:   rate_lap = val[LAP_W-1:0];
			CFG_TOTAL: rate_total = val;
			default:   ;
		endcase
		reg_writes++;
	endtask

	task automatic queue_req(logic func, logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec);
		tick_req_t r;
		r.func = func;
		r.sec = sec;
		r.usec = usec;
		req_queue.push_back(r);
		reqs_queued++;
	endtask

	// tick a little later than the last one on the wall clock
	task automatic queue_next_tick();
		int us;
		us = int'(wall_usec) + $urandom_range(1, 3000);
		while (us >= 1000000) begin
			us -= 1000000;
			wall_sec++;
		end
		wall_usec = us[USEC_W-1:0];
		queue_req(1'b0, wall_sec, wall_usec);
	endtask

	// Mostly well-paced ticks; some long forward jumps (any usec, also
	// past one second) and some finish requests with random stamps.
	task automatic queue_random(int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				queue_req(1'b1, $urandom, 20'($urandom_range(0, 20'hF_FFFF)));
			end else if (pick < 18) begin
				wall_sec = wall_sec + $urandom_range(2, 4000);
				wall_usec = 20'($urandom_range(0, 20'hF_FFFF));
				queue_req(1'b0, wall_sec, wall_usec);
			end else begin
				queue_next_tick();
			end
		end
	endtask

	task automatic pick_rates();
		logic [CFG_DATA_W-1:0] lap;
		case ($urandom_range(3))
			0:       lap = '0;
			1:       lap = $urandom_range(1, 16);
			2:       lap = $urandom_range(17, 500);
			default: lap = $urandom_range(0, 65535);
		endcase
		write_reg(CFG_PPT, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 63));
		write_reg(CFG_EPM, $urandom_range(0, 999));
		write_reg(CFG_LAP, lap);
		// keep the stream alive through the random part
		write_reg(CFG_TOTAL, $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
	endtask

	// Wait until every request is taken and every stamp is back, then let
	// dropped or stamp-less ticks clear the pipeline.
	task automatic settle();
		int waited;
		waited = 0;
		while ((reqs_taken != reqs_queued || stamps_due.size() != 0) && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reqs_taken != reqs_queued || stamps_due.size() != 0) begin
			$error("%0d requests not taken, %0d stamps still expected",
				reqs_queued - reqs_taken, stamps_due.size());
			fail_count++;
			stamps_due.delete();
		end
	endtask

	task automatic set_idle(int send, int stall);
		send_idle_pct = send;
		stall_pct = stall;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset rates: one stamp per tick. First stamp is start, the second
		// tick still has no gap, then gaps start to count.
		queue_req(1'b0, 32'd0, 20'd0);
		queue_req(1'b0, 32'd0, 20'd5);
		queue_req(1'b0, 32'd1, 20'd0);
		queue_req(1'b0, 32'd1, 20'd250);
		queue_req(1'b1, 32'hFFFF_FFFF, 20'hF_FFFF);
		queue_req(1'b1, 32'd0, 20'd0);
		queue_req(1'b0, 32'd1, 20'd999999);
		settle();

		// Largest tick with every stamp a lap and heavy credit.
		write_reg(CFG_PPT, 32'd63);
		write_reg(CFG_EPM, 32'd999);
		write_reg(CFG_LAP, 32'd1);
		write_reg(CFG_TOTAL, 32'hFFFF_FFFF);
		repeat (3) queue_next_tick();
		queue_req(1'b1, 32'h5555_5555, 20'h5_5555);
		settle();

		// No whole stamps: ticks that emit nothing but still move the gaps,
		// then credit above 1000 per tick giving one stamp each.
		write_reg(CFG_PPT, 32'd0);
		write_reg(CFG_EPM, 32'd0);
		write_reg(CFG_LAP, 32'd0);
		repeat (2) queue_next_tick();
		settle();
		write_reg(CFG_EPM, 32'd1023);
		repeat (3) queue_next_tick();
		settle();
		write_reg(CFG_LAP, 32'h0000_FFFF);
		write_reg(CFG_PPT, 32'd5);
		queue_next_tick();
		settle();

		// Random part: four idle mixes, two rate settings each.
		set_idle(0, 0);
		repeat (2) begin
			pick_rates();
			queue_random(55);
			settle();
		end
		set_idle(54, 0);
		repeat (2) begin
			pick_rates();
			queue_random(55);
			settle();
		end
		set_idle(0, 54);
		repeat (2) begin
			pick_rates();
			queue_random(55);
			settle();
		end
		set_idle(25, 25);
		repeat (2) begin
			pick_rates();
			queue_random(55);
			settle();
		end

		// Receiver holds off while full ticks keep coming, so the output
		// register and then the request side back up.
		set_idle(0, 0);
		write_reg(CFG_PPT, 32'd63);
		write_reg(CFG_EPM, 32'd500);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (12) queue_next_tick();
		settle();

		// Gap extremes: a jump too large for 32 bits, then time running back.
		write_reg(CFG_LAP, 32'd1);
		write_reg(CFG_EPM, 32'd999);
		queue_req(1'b0, 32'hFFFF_FFFF, 20'hF_FFFF);
		queue_req(1'b0, 32'd0, 20'd0);
		settle();

		// End of stream in the middle of a tick: the tenth stamp ends it,
		// every later stamp of the tick is end too, end beats lap.
		write_reg(CFG_TOTAL, seq_count + 32'd10);
		queue_req(1'b0, 32'h5555_5555, 20'hA_AAAA);
		settle();

		// Stopped stream: ticks vanish, finishes still count.
		write_reg(CFG_TOTAL, 32'd1);
		set_idle(25, 25);
		repeat (4) begin
			queue_req(1'b0, $urandom, 20'($urandom_range(0, 20'hF_FFFF)));
			queue_req(1'b1, $urandom, 20'($urandom_range(0, 20'hF_FFFF)));
		end
		settle();

		$display("Run covered %0d ticks and %0d finish requests, %0d stamps checked, %0d register writes",
			ticks_taken, finishes_taken, stamps_seen, reg_writes);
		$display("Saw %0d lap and %0d end markers; stream stopped at sequence %0d, gaps %0d..%0d us",
			lap_marks, end_marks, seq_count, gap_lo, gap_hi);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
